/* rtl/core/oaht_pkg.sv */
// Package for the open-addressing hash table: widths, codes and types.
// No dependencies.
package oaht_pkg;

    localparam int MaxSlots = 64;
    localparam int SlotW    = $clog2(MaxSlots);
    localparam int CntW     = SlotW + 1;
    localparam int KeyW     = 35;
    localparam int HandleW  = 32;
    localparam int HashW    = 23;
    localparam int QDepth   = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [KeyW-1:0]    key;
        logic [HashW-1:0]   hash;
        logic [HandleW-1:0] handle;
    } op_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        key_chars;
        logic [2:0]         key_length;
        logic [HandleW-1:0] record_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [HandleW-1:0] found_handle;
        logic [SlotW-1:0]   slot_index;
        logic               load_warning;
    } rsp_t;

endpackage

/* rtl/core/oaht_if.sv */
// Valid/ready channel interfaces for the hash table.
// Depends on oaht_pkg.
interface oaht_req_if import oaht_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface oaht_cfg_if ();
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/oaht_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
module oaht_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/oaht_front.sv */
// Front end: accepts requests, masks the key and folds the hash into a queue.
// Depends on oaht_pkg.
module oaht_front import oaht_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    output logic q_valid,
    input  logic q_pop,
    output op_t  q_op
);
    op_t             q_mem [QDepth];
    logic [0:0]      wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic [2:0]      len;
    logic [31:0]     masked;
    logic [HashW-1:0] d;
    op_t             op_w;
    logic            push;

    always_comb
    begin
        len    = (in_req.key_length > 3'd4) ? 3'd4 : in_req.key_length;
        masked = '0;
        d      = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (3'(j) < len)
            begin
                masked[31-8*j -: 8] = in_req.key_chars[31-8*j -: 8];
                d = HashW'(d * 5'd27) + HashW'(in_req.key_chars[31-8*j -: 8]);
            end
        end
        op_w.cmd    = in_req.cmd;
        op_w.key    = {len, masked};
        op_w.hash   = d;
        op_w.handle = in_req.record_handle;
    end

    assign in_ready = (cnt_reg != 2'(QDepth));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_op     = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= op_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

/* rtl/core/oaht_back.sv */
// Back end: modulo unit, probe sequencer, table update and result register.
// Depends on oaht_pkg and oaht_ram.
module oaht_back import oaht_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [6:0] slots_cfg,
    input  logic       q_valid,
    output logic       q_pop,
    input  op_t        q_op,
    output logic       out_valid,
    input  logic       out_ready,
    output rsp_t       out_rsp
);
    typedef enum logic [2:0] {S_IDLE, S_MOD, S_READ, S_CHECK, S_OUT} state_t;

    state_t           state_reg;
    op_t              op_reg;
    logic [HashW-1:0] rem_reg;
    logic [4:0]       sh_reg;
    logic [CntW-1:0]  n_reg;
    logic [SlotW-1:0] p_reg;
    logic [CntW-1:0]  i_reg;
    logic [CntW:0]    inc_reg;
    logic [CntW-1:0]  count_reg;
    logic [MaxSlots-1:0] occ_reg, act_reg;
    logic             rvalid_reg;
    rsp_t             rsp_reg;
    status_t          res_status_reg;
    logic [HandleW-1:0] res_handle_reg;
    logic [SlotW-1:0] res_slot_reg;

    logic [CntW-1:0]  n_eff;
    logic [HashW+CntW-1:0] trial;
    logic             key_we, hdl_we;
    logic [KeyW-1:0]  key_rd;
    logic [HandleW-1:0] hdl_rd;
    logic [CntW:0]    psum;
    logic [CntW-1:0]  pnext;
    logic [CntW:0]    inc_add;
    logic [CntW:0]    inc_next;
    logic             hit_stop;
    logic [CntW-1:0]  cnt_new;
    logic             out_load;

    assign n_eff = (slots_cfg == 7'd0) ? CntW'(1) :
                   (slots_cfg > 7'(MaxSlots)) ? CntW'(MaxSlots) : CntW'(slots_cfg);

    assign trial = {{HashW{1'b0}}, n_reg} << sh_reg;

    assign hit_stop = !occ_reg[p_reg] || (key_rd == op_reg.key);
    // p + (2i+1) mod n, increment kept below n
    assign psum  = (CntW+1)'(p_reg) + inc_reg;
    assign pnext = (psum >= (CntW+1)'(n_reg)) ?
                   CntW'(psum - (CntW+1)'(n_reg)) : CntW'(psum);
    assign inc_add  = inc_reg + (CntW+1)'(2);
    assign inc_next = (inc_add >= (CntW+1)'(n_reg)) ?
                      inc_add - (CntW+1)'(n_reg) : inc_add;
    assign cnt_new = (count_reg < n_reg) ? count_reg + 1'b1 : count_reg;

    assign key_we = (state_reg == S_CHECK) && hit_stop && (op_reg.cmd == CMD_INSERT);
    assign hdl_we = key_we;

    assign out_load = (state_reg == S_OUT) && (!rvalid_reg || out_ready);

    oaht_ram #(.Width(KeyW), .Depth(MaxSlots)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(p_reg), .wdata(op_reg.key),
        .raddr(p_reg), .rdata(key_rd)
    );

    oaht_ram #(.Width(HandleW), .Depth(MaxSlots)) u_hdl_ram (
        .clk(clk), .we(hdl_we), .waddr(p_reg), .wdata(op_reg.handle),
        .raddr(p_reg), .rdata(hdl_rd)
    );

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = rvalid_reg;
    assign out_rsp   = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            act_reg        <= '0;
            count_reg      <= '0;
            rvalid_reg     <= 1'b0;
            op_reg         <= '0;
            rem_reg        <= '0;
            sh_reg         <= '0;
            n_reg          <= '0;
            p_reg          <= '0;
            i_reg          <= '0;
            inc_reg        <= '0;
            rsp_reg        <= '0;
            res_status_reg <= ST_OK;
            res_handle_reg <= '0;
            res_slot_reg   <= '0;
        end
        else
        begin
            if (out_load)
            begin
                rvalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                rvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg  <= q_op;
                        rem_reg <= q_op.hash;
                        n_reg   <= n_eff;
                        sh_reg  <= 5'(HashW - 1);
                        state_reg <= (q_op.cmd == CMD_NOP) ? S_OUT : S_MOD;
                        res_status_reg <= ST_NOT_FOUND;
                        res_handle_reg <= '0;
                        res_slot_reg   <= '0;
                    end
                end
                S_MOD:
                begin
                    // restoring remainder, one shift per cycle
                    if ({{CntW{1'b0}}, rem_reg} >= trial)
                    begin
                        rem_reg <= rem_reg - HashW'(trial);
                    end
                    if (sh_reg == 5'd0)
                    begin
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        sh_reg <= sh_reg - 1'b1;
                    end
                end
                S_READ:
                begin
                    if (sh_reg == 5'd0 && i_reg == '0 && inc_reg == '0)
                    begin
                        p_reg   <= SlotW'(rem_reg);
                        inc_reg <= (CntW+1)'(1);
                        sh_reg  <= 5'd1;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (hit_stop)
                    begin
                        res_slot_reg <= p_reg;
                        unique case (op_reg.cmd)
                            CMD_INSERT:
                            begin
                                occ_reg[p_reg]  <= 1'b1;
                                act_reg[p_reg]  <= 1'b1;
                                count_reg       <= cnt_new;
                                res_status_reg  <= ST_OK;
                            end
                            CMD_LOOKUP:
                            begin
                                if (occ_reg[p_reg] && act_reg[p_reg])
                                begin
                                    res_status_reg <= ST_OK;
                                    res_handle_reg <= hdl_rd;
                                end
                            end
                            default:
                            begin
                                if (occ_reg[p_reg])
                                begin
                                    act_reg[p_reg] <= 1'b0;
                                    res_status_reg <= ST_OK;
                                end
                            end
                        endcase
                        state_reg <= S_OUT;
                    end
                    else if (i_reg + 1'b1 >= n_reg)
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        i_reg   <= i_reg + 1'b1;
                        p_reg   <= SlotW'(pnext);
                        inc_reg <= inc_next;
                        state_reg <= S_READ;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        rsp_reg.status       <= res_status_reg;
                        rsp_reg.found_handle <= res_handle_reg;
                        rsp_reg.slot_index   <= res_slot_reg;
                        rsp_reg.load_warning <= ({1'b0, count_reg} << 1) > (CntW+1)'(n_reg);
                        i_reg   <= '0;
                        inc_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* rtl/core/open_addressing_hash_table_top.sv */
// Top level of the open-addressing hash table: config register, front, back.
// Depends on oaht_pkg, oaht_if, oaht_front, oaht_back.
//
//  channel  dir  payload
//  req      in   cmd, key_chars, key_length, record_handle
//  rsp      out  status, found_handle, slot_index, load_warning
//  cfg      in   slots_in_use (7 bits)
//
// In the back end a request is popped, the bit-serial modulo runs, the home read is
// issued, each probe (1 to n probes) takes a read and a check through the registered
// slot RAM read, and the result is loaded. A no-op goes from the pop to the result load.
// Front queue holds two requests; a result waiting in the output register stalls the
// back end only once its next result is ready.
// Reset clears valid marks and count; slot RAM contents are not cleared.
module open_addressing_hash_table_top import oaht_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    oaht_req_if.sink     req,
    oaht_rsp_if.source   rsp,
    oaht_cfg_if.sink     cfg
);
    logic [6:0] slots_reg;
    logic       q_valid, q_pop;
    op_t        q_op;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= 7'(MaxSlots);
        end
        else if (cfg.valid)
        begin
            slots_reg <= cfg.data;
        end
    end

    oaht_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_req(req.payload),
        .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op)
    );

    oaht_back u_back (
        .clk(clk), .rst_n(rst_n), .slots_cfg(slots_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(rsp.payload)
    );
endmodule

/* bench/tb_pkg.sv */
// Shared bench package: expected-result field type.
// Depends on oaht_pkg.
package tb_pkg;
    import oaht_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] found_handle;
        logic [5:0]  slot_index;
        logic        load_warning;
    } table_result_t;
endpackage

/* bench/tb_if.sv */
// Bench interface file: the bench drives the RTL channel interfaces of oaht_if
// directly, so no further bench interfaces are declared here.

/* bench/tb_top.sv */
// Bench for the hash table: random and directed inserts, lookups, deletes and no-ops,
// checked against a behavioral table model kept in the bench.
// Depends on oaht_pkg, oaht_if, tb_pkg and the RTL top.
module tb_top;
    import oaht_pkg::*;
    import tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    oaht_req_if req ();
    oaht_rsp_if rsp ();
    oaht_cfg_if cfg ();

    open_addressing_hash_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always #5 clk = ~clk;

    // table model
    logic [34:0] tbl_key [64];
    logic [31:0] tbl_handle [64];
    bit          tbl_occ [64];
    bit          tbl_act [64];
    int unsigned tbl_count;
    int unsigned tbl_size;
    table_result_t pending_results [$];
    int          mismatches;
    bit          quiet_mode;
    logic [31:0] key_pool [16];
    logic [2:0]  key_pool_klen [16];

    function automatic table_result_t table_apply(logic [1:0] cmd, logic [31:0] chars,
                                                  logic [2:0] klen, logic [31:0] handle);
        table_result_t r;
        int unsigned len, d, home, p, i;
        logic [31:0] masked;
        logic [34:0] key;
        bit hit;
        len = (klen > 4) ? 4 : klen;
        d = 0;
        masked = '0;
        for (i = 0; i < len; i++)
        begin
            d = d * 27 + chars[31-8*i -: 8];
            masked[31-8*i -: 8] = chars[31-8*i -: 8];
        end
        key = {len[2:0], masked};
        r.status = ST_NOT_FOUND;
        r.found_handle = '0;
        r.slot_index = '0;
        if (cmd != CMD_NOP)
        begin
            home = d % tbl_size;
            hit = 1'b0;
            p = 0;
            for (i = 0; i < tbl_size && !hit; i++)
            begin
                p = (home + i * i) % tbl_size;
                if (!tbl_occ[p] || tbl_key[p] == key)
                    hit = 1'b1;
            end
            if (!hit)
            begin
                r.status = ST_FULL;
            end
            else if (cmd == CMD_INSERT)
            begin
                tbl_key[p] = key;
                tbl_handle[p] = handle;
                tbl_occ[p] = 1'b1;
                tbl_act[p] = 1'b1;
                if (tbl_count < tbl_size)
                    tbl_count++;
                r.status = ST_OK;
                r.slot_index = 6'(p);
            end
            else if (cmd == CMD_LOOKUP)
            begin
                r.slot_index = 6'(p);
                if (tbl_occ[p] && tbl_act[p])
                begin
                    r.status = ST_OK;
                    r.found_handle = tbl_handle[p];
                end
            end
            else
            begin
                r.slot_index = 6'(p);
                if (tbl_occ[p])
                begin
                    tbl_act[p] = 1'b0;
                    r.status = ST_OK;
                end
            end
        end
        r.load_warning = (tbl_count * 2 > tbl_size);
        return r;
    endfunction

    function automatic bit chance_idle();
        return !quiet_mode && ($urandom_range(99) < 17);
    endfunction

    // leaves valid high after the accepting edge; the next call drives a new item or drops it, a drain drops it
    task automatic send_request(logic [1:0] cmd, logic [31:0] chars, logic [2:0] klen,
                                logic [31:0] handle);
        req_t item;
        while (chance_idle())
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        item.cmd = cmd;
        item.key_chars = chars;
        item.key_length = klen;
        item.record_handle = handle;
        req.valid <= 1'b1;
        req.payload <= item;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.push_back(table_apply(cmd, chars, klen, handle));
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_slots(logic [6:0] value);
        drain_results();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        tbl_size = (value == 0) ? 1 : (value > 64) ? 64 : value;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= !chance_idle();
    end

    always @(posedge clk)
    begin
        table_result_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", rsp.payload);
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp.payload.status !== e.status
                        || rsp.payload.found_handle !== e.found_handle
                        || rsp.payload.slot_index !== e.slot_index
                        || rsp.payload.load_warning !== e.load_warning)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d h=%h s=%0d w=%0d %s",
                                 e.status, e.found_handle, e.slot_index, e.load_warning,
                                 $sformatf("got st=%0d h=%h s=%0d w=%0d",
                                           rsp.payload.status, rsp.payload.found_handle,
                                           rsp.payload.slot_index,
                                           rsp.payload.load_warning));
                end
            end
        end
    end

    function automatic logic [31:0] rand_code();
        logic [31:0] c;
        c[31:24] = 8'($urandom_range(65, 90));
        c[23:16] = 8'($urandom_range(65, 90));
        c[15:8] = 8'($urandom_range(65, 90));
        c[7:0] = 8'($urandom_range(65, 90));
        return c;
    endfunction

    task automatic test_directed();
        send_request(CMD_LOOKUP, "ABC ", 3, 32'h0);
        send_request(CMD_INSERT, "ABC ", 3, 32'hFFFF_FFFF);
        send_request(CMD_LOOKUP, "ABCZ", 3, 32'h1234);
        send_request(CMD_INSERT, "ABC ", 3, 32'h0);
        send_request(CMD_DELETE, "ABC ", 3, 32'h0);
        send_request(CMD_LOOKUP, "ABC ", 3, 32'h0);
        send_request(CMD_DELETE, "ABC ", 3, 32'h0);
        send_request(CMD_DELETE, "QQQQ", 4, 32'h0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 7, 32'hA5A5_A5A5);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 4, 32'h0);
        send_request(CMD_INSERT, 32'h0000_0000, 0, 32'h5A5A_5A5A);
        send_request(CMD_INSERT, 32'h0000_0000, 2, 32'h1);
        send_request(CMD_LOOKUP, 32'h0000_0000, 0, 32'h0);
        send_request(CMD_NOP, "ABC ", 3, 32'h0);
        send_request(CMD_INSERT, 32'h8000_0000, 5, 32'h2);
        send_request(CMD_LOOKUP, 32'h8000_0000, 6, 32'h0);
    endtask

    task automatic test_tiny_tables();
        int i;
        write_slots(7'd0);
        for (i = 0; i < 6; i++)
            send_request(2'($urandom_range(2)), rand_code(), 3'd4, $urandom);
        write_slots(7'd2);
        for (i = 0; i < 10; i++)
            send_request(2'($urandom_range(2)), rand_code(), 3'($urandom_range(1, 2)),
                         $urandom);
        write_slots(7'd127);
        for (i = 0; i < 10; i++)
            send_request(2'($urandom_range(3)), $urandom, 3'($urandom_range(7)), $urandom);
    endtask

    task automatic test_random(int count, logic [6:0] size);
        int i, k;
        logic [1:0] cmd;
        write_slots(size);
        for (k = 0; k < 16; k++)
        begin
            key_pool[k] = rand_code();
            key_pool_klen[k] = 3'($urandom_range(1, 4));
        end
        for (i = 0; i < count; i++)
        begin
            quiet_mode = (i > count / 2) && (i < count / 2 + 60);
            cmd = ($urandom_range(99) < 3) ? CMD_NOP : 2'($urandom_range(2));
            if ($urandom_range(9) < 7)
            begin
                k = $urandom_range(15);
                send_request(cmd, key_pool[k], key_pool_klen[k], $urandom);
            end
            else
                send_request(cmd, $urandom, 3'($urandom_range(7)), $urandom);
        end
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.payload = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        tbl_count = 0;
        tbl_size = 64;
        mismatches = 0;
        quiet_mode = 1'b0;
        for (int i = 0; i < 64; i++)
        begin
            tbl_occ[i] = 1'b0;
            tbl_act[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_tiny_tables();
        test_random(500, 7'd64);
        test_random(450, 7'd13);
        test_random(450, 7'd37);
        test_random(400, 7'd1);
        drain_results();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/oaht_pkg.sv
rtl/core/oaht_if.sv
rtl/core/oaht_ram.sv
rtl/core/oaht_front.sv
rtl/core/oaht_back.sv
rtl/core/open_addressing_hash_table_top.sv
bench/tb_pkg.sv
bench/tb_if.sv
bench/tb_top.sv
